// ----- hw/rtl/bf5h_pkg.sv -----
package bf5h_pkg;

  localparam int FILTER_BITS = 256;
  localparam int IDX_W       = $clog2(FILTER_BITS);
  localparam int KEY_W       = 31;
  localparam int NUM_HASH    = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // golden-ratio fraction in unsigned q0.32
  localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;

  localparam int MOD_A = 43;
  localparam int MOD_B = 197;

  // reciprocals floor(2^32 / m), quotient estimate is low by at most one
  localparam int          Q32_SHIFT = 32;
  localparam logic [32:0] Q32_ONE   = 33'h1_0000_0000;
  localparam int          RECIP_A_W = 27;
  localparam int          RECIP_B_W = 25;
  localparam int          QA_W      = KEY_W + RECIP_A_W - Q32_SHIFT;
  localparam int          QB_W      = KEY_W + RECIP_B_W - Q32_SHIFT;
  localparam logic [RECIP_A_W-1:0] RECIP_A = RECIP_A_W'(Q32_ONE / MOD_A);
  localparam logic [RECIP_B_W-1:0] RECIP_B = RECIP_B_W'(Q32_ONE / MOD_B);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    func_t                     func;
    idx_t [NUM_HASH-1:0]       idx;
  } probe_t;

endpackage

// ----- hw/rtl/bf5h_hash.sv -----
module bf5h_hash (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  bf5h_pkg::item_t  item,
  output logic             probe_valid,
  input  logic             probe_ready,
  output bf5h_pkg::probe_t probe
);
  import bf5h_pkg::*;

  localparam int PA_W = KEY_W + RECIP_A_W;
  localparam int PB_W = KEY_W + RECIP_B_W;

  logic             s1_v_r, s1_v_nxt;
  func_t            s1_func_r;
  logic [KEY_W-1:0] s1_key_r;
  idx_t             s1_gold_r;
  logic [QA_W-1:0]  s1_qa_r;
  logic [QB_W-1:0]  s1_qb_r;

  logic             s2_v_r, s2_v_nxt;
  probe_t           s2_probe_r, s2_probe_nxt;

  logic             s1_ready, s2_ready;
  logic [31:0]      gold_prod;
  logic [PA_W-1:0]  prod_a;
  logic [PB_W-1:0]  prod_b;
  logic [31:0]      diff_a, diff_b;
  logic [6:0]       ra_raw;
  logic [8:0]       rb_raw;
  logic [5:0]       ra;
  logic [7:0]       rb;

  assign s2_ready   = !s2_v_r || probe_ready;
  assign s1_ready   = !s1_v_r || s2_ready;
  assign item_ready = s1_ready;

  // stage 1: golden-ratio product and reciprocal quotient estimates
  assign gold_prod = 32'(item.key) * GOLDEN_Q32;
  assign prod_a    = PA_W'(item.key) * PA_W'(RECIP_A);
  assign prod_b    = PB_W'(item.key) * PB_W'(RECIP_B);

  assign s1_v_nxt = s1_ready ? item_valid : s1_v_r;

  // stage 2: remainders with one correction step, then the five indexes
  assign diff_a = 32'(s1_key_r) - 32'(s1_qa_r) * 32'(MOD_A);
  assign diff_b = 32'(s1_key_r) - 32'(s1_qb_r) * 32'(MOD_B);
  assign ra_raw = diff_a[6:0];
  assign rb_raw = diff_b[8:0];
  assign ra     = (ra_raw >= 7'(MOD_A)) ? 6'(ra_raw - 7'(MOD_A)) : 6'(ra_raw);
  assign rb     = (rb_raw >= 9'(MOD_B)) ? 8'(rb_raw - 9'(MOD_B)) : 8'(rb_raw);

  always_comb begin
    s2_probe_nxt.func   = s1_func_r;
    s2_probe_nxt.idx[0] = s1_key_r[IDX_W-1:0];
    s2_probe_nxt.idx[1] = s1_gold_r;
    s2_probe_nxt.idx[2] = IDX_W'(ra);
    s2_probe_nxt.idx[3] = s1_key_r[IDX_W-1:0] ^ s1_key_r[IDX_W+2:3];
    s2_probe_nxt.idx[4] = IDX_W'(FILTER_BITS - 1) - IDX_W'(rb);
  end

  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && item_valid) begin
      s1_func_r <= item.func;
      s1_key_r  <= item.key;
      s1_gold_r <= gold_prod[31 -: IDX_W];
      s1_qa_r   <= prod_a[Q32_SHIFT +: QA_W];
      s1_qb_r   <= prod_b[Q32_SHIFT +: QB_W];
    end
    if (s2_ready && s1_v_r) begin
      s2_probe_r <= s2_probe_nxt;
    end
  end

  assign probe_valid = s2_v_r;
  assign probe       = s2_probe_r;

endmodule

// ----- hw/rtl/bf5h_filter.sv -----
module bf5h_filter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             probe_valid,
  output logic             probe_ready,
  input  bf5h_pkg::probe_t probe,
  output logic             res_valid,
  input  logic             res_ready,
  output logic             res_present
);
  import bf5h_pkg::*;

  logic [FILTER_BITS-1:0] filter_r, filter_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_present_r;
  logic [FILTER_BITS-1:0] set_mask;
  logic                   out_free;
  logic                   go;
  logic                   is_insert;
  logic                   hit;

  assign is_insert   = (probe.func == FUNC_INSERT);
  assign out_free    = !out_valid_r || res_ready;
  assign probe_ready = is_insert || out_free;
  assign go          = probe_valid && probe_ready;

  always_comb begin
    hit      = 1'b1;
    set_mask = '0;
    for (int i = 0; i < NUM_HASH; i++) begin
      hit                   = hit & filter_r[probe.idx[i]];
      set_mask[probe.idx[i]] = 1'b1;
    end
  end

  always_comb begin
    filter_nxt    = filter_r;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (go) begin
      if (is_insert) begin
        filter_nxt = filter_r | set_mask;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      filter_r    <= filter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && !is_insert) begin
      out_present_r <= hit;
    end
  end

  assign res_valid   = out_valid_r;
  assign res_present = out_present_r;

endmodule

// ----- hw/rtl/bloom_filter_256_five_hash.sv -----
// 256-bit bloom filter with five fixed hashes of a 31-bit key
// input stream: each transfer carries an operation on tuser and a key on
//   tdata; an insert sets the five hashed filter bits and gives no result,
//   a query gives exactly one result transfer
// output stream: present is 1 when all five hashed bits of the key are set
// a query result passes the input register, product stage, index stage,
//   then the filter access and result register
// throughput: one item per cycle unless the receiver stalls; the filter flops
//   are read and set in one stage, so a query sees every insert taken before it
// reset clears the filter and all valid flags directly, no clear pass
// when the receiver stalls, the result register holds its item, inserts
//   still drain, and the pipeline fills before in_tready drops
module bloom_filter_256_five_hash (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,   // func
  input  logic [bf5h_pkg::IN_TDATA_W-1:0]  in_tdata,   // key, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bf5h_pkg::OUT_TDATA_W-1:0] out_tdata   // present, zero pad
);
  import bf5h_pkg::*;

  logic   s0_v_r, s0_v_nxt;
  item_t  s0_item_r;
  logic   hash_ready;
  logic   probe_valid;
  logic   probe_ready;
  probe_t probe;
  logic   present;

  assign in_tready = !s0_v_r || hash_ready;
  assign s0_v_nxt  = in_tready ? in_tvalid : s0_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= s0_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_item_r.func <= func_t'(in_tuser);
      s0_item_r.key  <= in_tdata[KEY_W-1:0];
    end
  end

  bf5h_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (s0_v_r),
    .item_ready  (hash_ready),
    .item        (s0_item_r),
    .probe_valid (probe_valid),
    .probe_ready (probe_ready),
    .probe       (probe)
  );

  bf5h_filter u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .probe_valid (probe_valid),
    .probe_ready (probe_ready),
    .probe       (probe),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_present (present)
  );

  assign out_tdata = {(OUT_TDATA_W - 1)'(0), present};

endmodule

// ----- bench/tb.sv -----
module tb;
  import bf5h_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tuser = 1'b0;  // func
  logic [IN_TDATA_W-1:0] in_tdata = '0;  // key, zero pad
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // present, zero pad

  item_t pending_q[$];
  logic expected_present_q[$];
  logic [FILTER_BITS-1:0] filter_model = '0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  bloom_filter_256_five_hash dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("bloom_filter_256_five_hash regression: fail");
    $finish;
  end

  function automatic logic [NUM_HASH-1:0][IDX_W-1:0] filter_probes(logic [KEY_W-1:0] key);
    logic [NUM_HASH-1:0][IDX_W-1:0] idx;
    logic [31:0] k;
    logic [31:0] golden;
    logic [31:0] folded;
    k = {1'b0, key};
    golden = k * GOLDEN_Q32;
    folded = k ^ (k >> 3);
    idx[0] = k[7:0];
    idx[1] = golden[31:24];
    idx[2] = IDX_W'(k % MOD_A);
    idx[3] = folded[7:0];
    idx[4] = IDX_W'(32'd255 - (k % MOD_B));
    return idx;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // apply one accepted transfer to the filter copy
  task automatic track_item(func_t f, logic [KEY_W-1:0] key);
    logic [NUM_HASH-1:0][IDX_W-1:0] idx;
    logic all_set;
    idx = filter_probes(key);
    if (f == FUNC_INSERT) begin
      for (int i = 0; i < NUM_HASH; i++) filter_model[idx[i]] = 1'b1;
    end else begin
      all_set = 1'b1;
      for (int i = 0; i < NUM_HASH; i++) all_set &= filter_model[idx[i]];
      expected_present_q.push_back(all_set);
    end
  endtask

  always @(posedge clk) begin : stream_driver
    item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        in_tuser <= nxt.func;
        in_tdata <= {1'b0, nxt.key};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    logic want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_present_q.size() == 0) begin
          report_mismatch("result transfer with no query pending");
        end else begin
          want = expected_present_q.pop_front();
          if (out_tdata[0] !== want)
            report_mismatch($sformatf("present got %b want %b", out_tdata[0], want));
        end
      end
      if (in_tvalid && in_tready) track_item(func_t'(in_tuser), in_tdata[KEY_W-1:0]);
    end
  end

  task automatic push_item(func_t f, logic [KEY_W-1:0] k);
    item_t it;
    it.func = f;
    it.key = k;
    pending_q.push_back(it);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom());
  endfunction

  // inserts stay mostly inside a small key pool so the filter never saturates
  task automatic push_random();
    int pick;
    logic [KEY_W-1:0] k;
    if ($urandom_range(99) < 25) begin
      k = ($urandom_range(99) < 97) ? key_pool[$urandom_range(POOL_SIZE-1)] : any_key();
      push_item(FUNC_INSERT, k);
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) k = key_pool[$urandom_range(POOL_SIZE-1)];
      else if (pick < 60) k = KEY_W'($urandom_range(1023));
      else k = any_key();
      push_item(FUNC_QUERY, k);
    end
  endtask

  task automatic wait_sender_done();
    do @(negedge clk); while (pending_q.size() > 0 || in_tvalid);
  endtask

  task automatic wait_drained();
    wait_sender_done();
    while (expected_present_q.size() > 0) @(negedge clk);
  endtask

  initial begin
    int guard;
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = (i % 2 == 0) ? any_key() : KEY_W'($urandom_range(4095));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty filter, key extremes, repeated indexes, overlapping hashes
    push_item(FUNC_QUERY, 31'h0000_0000);
    push_item(FUNC_QUERY, 31'h7FFF_FFFF);
    push_item(FUNC_INSERT, 31'h0000_0000);
    push_item(FUNC_QUERY, 31'h0000_0000);
    push_item(FUNC_QUERY, 31'h0000_0100);
    push_item(FUNC_INSERT, 31'h7FFF_FFFF);
    push_item(FUNC_QUERY, 31'h7FFF_FFFF);
    push_item(FUNC_INSERT, 31'd43);
    push_item(FUNC_QUERY, 31'd86);
    push_item(FUNC_INSERT, 31'd197);
    push_item(FUNC_QUERY, 31'd394);
    push_item(FUNC_INSERT, 31'h5555_5555);
    push_item(FUNC_QUERY, 31'h2AAA_AAAA);
    push_item(FUNC_QUERY, 31'h5555_5555);
    push_item(FUNC_INSERT, 31'd1);
    push_item(FUNC_INSERT, 31'd1);
    push_item(FUNC_QUERY, 31'd1);
    push_item(FUNC_QUERY, 31'd8);
    push_item(FUNC_QUERY, 31'h4000_0000);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) push_random();
      // sender holds off until every query of the phase has answered
      wait_drained();
    end

    wait_sender_done();
    guard = 0;
    while (expected_present_q.size() > 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (expected_present_q.size() > 0)
      report_mismatch($sformatf("%0d query results never arrived", expected_present_q.size()));
    if (errors == 0) begin
      $display("bloom_filter_256_five_hash regression: pass");
    end else begin
      $display("bloom_filter_256_five_hash regression: fail");
    end
    $finish;
  end

endmodule
